[rtl/gpsp_pkg.sv]
// gpsp_pkg: shared types and constants for the gamepad serial poll master.
// No dependencies; used by gamepad_serial_poll_master.
package gpsp_pkg;

  localparam int FRAME_BYTES_DEF = 9;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_HALF_BIT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COMMAND_GAP = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DATA_GAP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_CMD   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_CMD  = 3'd4;

  localparam logic [15:0] HALF_BIT_RST    = 16'd10;
  localparam logic [15:0] COMMAND_GAP_RST = 16'd16;
  localparam logic [15:0] DATA_GAP_RST    = 16'd10;
  localparam logic [7:0]  FIRST_CMD_RST   = 8'h01;
  localparam logic [7:0]  SECOND_CMD_RST  = 8'h42;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic       frame_done;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    logic       byte_valid;
    logic       command_line;
    logic       clock_line;
    logic       select_line;
  } result_t;

endpackage

[rtl/gamepad_serial_poll_master.sv]
// gamepad_serial_poll_master: poll frame sequencer for an LSB-first serial gamepad link.
// Depends on gpsp_pkg (phase type, result layout, register indexes, reset values).
//
// Usage: each transfer on the s_ channel is one item: s_tuser = 1 asks for a frame
// to start, s_tuser = 0 means one tick has passed; s_tdata[0] is the data pin level.
// Every input item yields exactly one result on the m_ channel carrying the line
// levels after that item, a received byte with its slot number when one completes
// in any slot but slot 0, and a frame-done flag on the item that ends the frame.
// Timing: the result is registered and appears in the output register in the cycle
// after the input transfer. Throughput: one item per cycle while the receiver takes
// results, set by the single result register that follows the state update logic.
// When the receiver stalls, the finished result is held and s_tready drops only
// if the output register is full and m_tready is low.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr; write only while no
// transfer is in flight. A write mid-frame takes effect at once. Unknown indexes
// are ignored.
// Reset (rst, synchronous): block idle, registers at their defaults, output register
// empty; the result register itself is not reset.
module gamepad_serial_poll_master #(
  parameter int FRAME_BYTES = gpsp_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gpsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gpsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [0] data_pin, [7:1] zero
  input  logic                            s_tuser,  // [0] kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] select_line, [1] clock_line, [2] command_line, [3] byte_valid,
  // [7:4] byte_index, [15:8] byte_value, [16] frame_done, [23:17] zero
  output logic [23:0]                     m_tdata
);

  localparam int CW = $clog2(FRAME_BYTES);
  localparam logic [CW-1:0] LAST_SLOT = CW'(FRAME_BYTES - 1);

  logic [15:0] half_bit_ticks;
  logic [15:0] command_gap_ticks;
  logic [15:0] data_gap_ticks;
  logic [7:0]  first_command;
  logic [7:0]  second_command;

  gpsp_pkg::phase_t phase, phase_next;
  logic [15:0]   tick_count, tick_next;
  logic [2:0]    bit_count, bit_next;
  logic [CW-1:0] byte_count, byte_next;
  logic [7:0]    receive_shift, shift_next;
  logic          command_level, cmd_next;

  gpsp_pkg::result_t res, res_next;
  logic              res_valid;

  logic        s_acc;
  logic [15:0] tick_inc;
  logic [15:0] gap_len;
  logic        half_end;
  logic        gap_end;
  logic        do_next;
  logic [7:0]  shift_or;

  function automatic logic cmd_bit(input logic [CW-1:0] slot, input logic [2:0] b,
                                   input logic [7:0] c0, input logic [7:0] c1);
    logic r;
    r = 1'b0;
    if (slot == CW'(0)) r = c0[b];
    else if (slot == CW'(1)) r = c1[b];
    return r;
  endfunction

  assign s_tready = !res_valid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = res_valid;
  assign m_tdata  = {7'd0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks    <= gpsp_pkg::HALF_BIT_RST;
      command_gap_ticks <= gpsp_pkg::COMMAND_GAP_RST;
      data_gap_ticks    <= gpsp_pkg::DATA_GAP_RST;
      first_command     <= gpsp_pkg::FIRST_CMD_RST;
      second_command    <= gpsp_pkg::SECOND_CMD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gpsp_pkg::REG_HALF_BIT:    half_bit_ticks    <= cfg_wdata;
        gpsp_pkg::REG_COMMAND_GAP: command_gap_ticks <= cfg_wdata;
        gpsp_pkg::REG_DATA_GAP:    data_gap_ticks    <= cfg_wdata;
        gpsp_pkg::REG_FIRST_CMD:   first_command     <= cfg_wdata[7:0];
        gpsp_pkg::REG_SECOND_CMD:  second_command    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    tick_next  = tick_count;
    bit_next   = bit_count;
    byte_next  = byte_count;
    shift_next = receive_shift;
    cmd_next   = command_level;
    do_next    = 1'b0;
    res_next   = '0;

    tick_inc = tick_count + 16'd1;
    gap_len  = (byte_count < CW'(2)) ? command_gap_ticks : data_gap_ticks;
    half_end = (tick_inc >= half_bit_ticks) || (tick_inc == 16'd0);
    gap_end  = (tick_inc >= gap_len) || (tick_inc == 16'd0);
    shift_or = receive_shift | (8'(s_tdata[0]) << bit_count);

    if (s_tuser) begin
      if (phase == gpsp_pkg::PH_IDLE) begin
        phase_next = gpsp_pkg::PH_HIGH;
        tick_next  = '0;
        bit_next   = '0;
        byte_next  = '0;
        shift_next = '0;
        cmd_next   = cmd_bit(CW'(0), 3'd0, first_command, second_command);
      end
    end else begin
      unique case (phase)
        gpsp_pkg::PH_IDLE: ;
        gpsp_pkg::PH_HIGH: begin
          tick_next = tick_inc;
          if (half_end) begin
            phase_next = gpsp_pkg::PH_LOW;
            tick_next  = '0;
          end
        end
        gpsp_pkg::PH_LOW: begin
          tick_next = tick_inc;
          if (half_end) begin
            tick_next  = '0;
            shift_next = shift_or;
            if (bit_count == 3'd7) begin
              if (byte_count != CW'(0)) begin
                res_next.byte_valid = 1'b1;
                res_next.byte_index = 4'(byte_count);
                res_next.byte_value = shift_or;
              end
              bit_next = '0;
              if (gap_len == 16'd0) do_next = 1'b1;
              else phase_next = gpsp_pkg::PH_GAP;
            end else begin
              bit_next   = bit_count + 3'd1;
              phase_next = gpsp_pkg::PH_HIGH;
              cmd_next   = cmd_bit(byte_count, bit_count + 3'd1, first_command,
                                   second_command);
            end
          end
        end
        gpsp_pkg::PH_GAP: begin
          tick_next = tick_inc;
          if (gap_end) do_next = 1'b1;
        end
        default: ;
      endcase
    end

    if (do_next) begin
      if (byte_count == LAST_SLOT) begin
        phase_next          = gpsp_pkg::PH_IDLE;
        tick_next           = '0;
        bit_next            = '0;
        byte_next           = '0;
        cmd_next            = 1'b0;
        res_next.frame_done = 1'b1;
      end else begin
        byte_next  = byte_count + CW'(1);
        phase_next = gpsp_pkg::PH_HIGH;
        tick_next  = '0;
        bit_next   = '0;
        shift_next = '0;
        cmd_next   = cmd_bit(byte_count + CW'(1), 3'd0, first_command, second_command);
      end
    end

    res_next.select_line  = (phase_next == gpsp_pkg::PH_IDLE);
    res_next.clock_line   = (phase_next != gpsp_pkg::PH_LOW);
    res_next.command_line = (phase_next == gpsp_pkg::PH_IDLE) ? 1'b0 : cmd_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= gpsp_pkg::PH_IDLE;
      tick_count    <= '0;
      bit_count     <= '0;
      byte_count    <= '0;
      receive_shift <= '0;
      command_level <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (s_acc) begin
        phase         <= phase_next;
        tick_count    <= tick_next;
        bit_count     <= bit_next;
        byte_count    <= byte_next;
        receive_shift <= shift_next;
        command_level <= cmd_next;
        res_valid     <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) res <= res_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_done) |-> (res.select_line && res.clock_line))
    else $error("frame_done without idle lines");

  a_byte_index: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.byte_valid) |-> (res.byte_index != 4'd0))
    else $error("byte reported with bad slot");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == gpsp_pkg::PH_IDLE) |-> (tick_count == 16'd0 && bit_count == 3'd0 &&
                                      byte_count == CW'(0)))
    else $error("idle with counters not clear");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tuser && phase == gpsp_pkg::PH_IDLE) |=>
      (phase == gpsp_pkg::PH_HIGH && byte_count == CW'(0)))
    else $error("start did not begin the first slot");

endmodule
